// File: rtl/eftr_pkg.sv
// ----------------------------------------------------------------------------
// eftr_pkg
// Shared types and constants of the edge-function triangle rasterizer.
// ----------------------------------------------------------------------------
package eftr_pkg;

  localparam int CFG_ADDR_W = 4;

  // Screen coordinate bits; frame sizes above 1 << COORD_BITS are limited.
  localparam int COORD_BITS = 12;

  // Register byte addresses.
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 4'h0;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 4'h4;
  localparam logic [CFG_ADDR_W-1:0] REG_DRAW_MODE    = 4'h8;
  localparam logic [CFG_ADDR_W-1:0] REG_EDGE_WIDTH   = 4'hC;

  localparam logic [1:0] MODE_GRAY = 2'd0;
  localparam logic [1:0] MODE_BARY = 2'd1;
  localparam logic [1:0] MODE_WIRE = 2'd2;
  localparam logic [1:0] MODE_RSVD = 2'd3;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAPX,
    ST_MAPY,
    ST_SETUP,
    ST_AREA,
    ST_EDGE,
    ST_DIV0,
    ST_DIV1,
    ST_COLOR,
    ST_OUT
  } state_e;

  // Divider handshake between the sequencer and the divider.
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

// File: rtl/eftr_div.sv
// ----------------------------------------------------------------------------
// eftr_div
// Restoring unsigned divider, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module eftr_div #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  eftr_pkg::div_ctl_t   ctl_i,
  input  logic [NUM_W-1:0]     num_i,
  input  logic [DEN_W-1:0]     den_i,
  output eftr_pkg::div_sts_t   sts_o,
  output logic [NUM_W-1:0]     quo_o
);
  import eftr_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W:0]   rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [DEN_W:0]   trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = '0;
    if (ctl_i.start) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CNT_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift one numerator bit into the partial remainder
      trial = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quo_o      = quo_q;

endmodule

// File: rtl/edge_function_triangle_raster.sv
// ----------------------------------------------------------------------------
// edge_function_triangle_raster
// Edge-function triangle rasterizer: vertex load, box setup, pixel scan.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake
//  in       | input     | in_valid_i / in_stall_o
//  out      | output    | out_valid_o / out_stall_i
//  cfg      | input     | APB write/read, pready tied high
//
//  A load with a select below three passes through the MAPX and MAPY states.
//  A step in gray mode or on an uncovered pixel passes through setup, the edge
//  products, color, the result beat and idle. A covered pixel of nonzero area
//  in barycentric or wireframe mode adds two passes of the shared bit-serial
//  divider. The first step after a load adds the area products; an empty box
//  goes from them straight to color. Reset is asynchronous; out_stall_i holds
//  the result beat. in_stall_o is high from acceptance until the item is done.
// ----------------------------------------------------------------------------
module edge_function_triangle_raster #(
  parameter int FRAC_BITS  = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             command_i,
  input  logic [1:0]                       vertex_select_i,
  input  logic signed [15:0]               ndc_x_i,
  input  logic signed [15:0]               ndc_y_i,
  input  logic signed [15:0]               ndc_z_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [11:0]                      pixel_x_o,
  output logic [11:0]                      pixel_y_o,
  output logic                             write_pixel_o,
  output logic [7:0]                       red_o,
  output logic [7:0]                       green_o,
  output logic [7:0]                       blue_o,
  output logic                             last_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [eftr_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import eftr_pkg::*;

  localparam int CW    = 14;              // signed vertex pixel width
  localparam int SZ_W  = COORD_BITS + 1;  // frame size after limiting
  localparam int DET_W = 32;
  localparam int NUM_W = DET_W + FRAC_BITS;
  localparam logic [12:0] SIZE_LIM = 13'(1 << COORD_BITS);
  localparam logic [NUM_W-1:0] ONE = NUM_W'(1) << FRAC_BITS;

  // ---------------- configuration ----------------
  logic [12:0] fw_q, fh_q;
  logic [1:0]  mode_q;
  logic [15:0] ew_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q   <= 13'd640;
      fh_q   <= 13'd480;
      mode_q <= MODE_GRAY;
      ew_q   <= 16'd3277;
    end else if (cfg_wr) begin
      case (paddr)
        REG_FRAME_WIDTH:  fw_q   <= pwdata[12:0];
        REG_FRAME_HEIGHT: fh_q   <= pwdata[12:0];
        REG_DRAW_MODE:    mode_q <= pwdata[1:0];
        REG_EDGE_WIDTH:   ew_q   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      REG_FRAME_WIDTH:  prdata = {19'd0, fw_q};
      REG_FRAME_HEIGHT: prdata = {19'd0, fh_q};
      REG_DRAW_MODE:    prdata = {30'd0, mode_q};
      REG_EDGE_WIDTH:   prdata = {16'd0, ew_q};
      default:          prdata = '0;
    endcase
  end

  logic [SZ_W-1:0] eff_w, eff_h;
  assign eff_w = (fw_q > SIZE_LIM) ? SZ_W'(SIZE_LIM) : SZ_W'(fw_q);
  assign eff_h = (fh_q > SIZE_LIM) ? SZ_W'(SIZE_LIM) : SZ_W'(fh_q);

  // ---------------- state ----------------
  state_e st_q, st_d;
  logic signed [CW-1:0] vx_q [3];
  logic signed [CW-1:0] vy_q [3];
  logic signed [15:0]   z0_q;
  logic [12:0]          bx0_q, bx1_q, by0_q, by1_q;
  logic [12:0]          sx_q, sy_q;
  logic [DET_W-1:0]     area_q;
  logic                 setup_q;
  logic [1:0]           sel_q;
  logic signed [15:0]   nx_q, ny_q;
  logic signed [DET_W-1:0] e0_q, e1_q, e2_q;
  logic [1:0]           eidx_q;
  logic [NUM_W-1:0]     b0_q;
  logic [11:0]          opx_q, opy_q;
  logic                 owr_q, olast_q;
  logic [7:0]           or_q, og_q, ob_q;

  // Shared multiplier: one signed product per cycle.
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  assign mul_p = mul_a * mul_b;

  div_ctl_t         dctl;
  div_sts_t         dsts;
  logic [NUM_W-1:0] dnum, dquo;

  eftr_div #(.NUM_W(NUM_W), .DEN_W(DET_W)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (dctl),
    .num_i  (dnum),
    .den_i  (area_q),
    .sts_o  (dsts),
    .quo_o  (dquo)
  );

  // Map operands for a coordinate.
  logic signed [CW-1:0] map_res;
  logic signed [63:0] map_num;

  // edge operands
  logic signed [CW-1:0] ea_x, ea_y, eb_x, eb_y;
  logic signed [CW:0]   dx_a, dy_a, dx_p, dy_p;
  logic signed [DET_W-1:0] edet;

  // setup: box and area operands
  logic signed [CW-1:0] mnx, mxx, mny, mxy;
  logic [12:0] nbx0, nbx1, nby0, nby1;
  logic signed [DET_W-1:0] area_s;

  function automatic logic signed [CW-1:0] min3(logic signed [CW-1:0] a,
      logic signed [CW-1:0] b, logic signed [CW-1:0] c);
    logic signed [CW-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic signed [CW-1:0] max3(logic signed [CW-1:0] a,
      logic signed [CW-1:0] b, logic signed [CW-1:0] c);
    logic signed [CW-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic logic [12:0] clo(logic signed [CW-1:0] lo, logic [SZ_W-1:0] sz);
    logic signed [CW:0] l;
    l = (lo < 0) ? '0 : (CW+1)'(lo);
    if (l > $signed({1'b0, CW'(sz)})) l = $signed({1'b0, CW'(sz)});
    return 13'(l);
  endfunction

  function automatic logic [12:0] chi(logic signed [CW-1:0] hi, logic [SZ_W-1:0] sz,
      logic [12:0] lo);
    logic signed [CW:0] h;
    h = (hi > $signed({1'b0, CW'(sz)})) ? $signed({1'b0, CW'(sz)}) : (CW+1)'(hi);
    if (h < $signed({2'b0, lo})) h = $signed({2'b0, lo});
    return 13'(h);
  endfunction

  function automatic logic signed [16:0] ndc_off(logic signed [15:0] c);
    return 17'(c) + 17'sd16384;
  endfunction

  always_comb begin
    mnx  = min3(vx_q[0], vx_q[1], vx_q[2]);
    mxx  = max3(vx_q[0], vx_q[1], vx_q[2]);
    mny  = min3(vy_q[0], vy_q[1], vy_q[2]);
    mxy  = max3(vy_q[0], vy_q[1], vy_q[2]);
    nbx0 = clo(mnx, eff_w);
    nbx1 = chi(mxx, eff_w, nbx0);
    nby0 = clo(mny, eff_h);
    nby1 = chi(mxy, eff_h, nby0);
  end

  // Edge eidx: from vertex a to vertex b, evaluated at (px, py).
  always_comb begin
    case (eidx_q)
      2'd0:    begin ea_x = vx_q[0]; ea_y = vy_q[0]; eb_x = vx_q[1]; eb_y = vy_q[1]; end
      2'd1:    begin ea_x = vx_q[1]; ea_y = vy_q[1]; eb_x = vx_q[2]; eb_y = vy_q[2]; end
      default: begin ea_x = vx_q[2]; ea_y = vy_q[2]; eb_x = vx_q[0]; eb_y = vy_q[0]; end
    endcase
    dx_a = (CW+1)'(eb_x) - (CW+1)'(ea_x);
    dy_a = (CW+1)'(eb_y) - (CW+1)'(ea_y);
    if (st_q == ST_AREA) begin
      // area uses vertex 2 relative to vertex 0, edge 0 operands
      dx_p = (CW+1)'(vx_q[2]) - (CW+1)'(vx_q[0]);
      dy_p = (CW+1)'(vy_q[2]) - (CW+1)'(vy_q[0]);
    end else begin
      dx_p = $signed({2'b0, sx_q}) - (CW+1)'(ea_x);
      dy_p = $signed({2'b0, sy_q}) - (CW+1)'(ea_y);
    end
  end

  // Two products per determinant; the multiplier is used twice.
  logic signed [DET_W-1:0] prod_q;
  logic                    half_q;
  logic [NUM_W-1:0]        b1c, b2c, thr;
  logic signed [31:0]      gray;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st_q)
      ST_MAPX: begin
        mul_a = 32'(ndc_off(nx_q));
        mul_b = {19'd0, 13'(eff_w)};
      end
      ST_MAPY: begin
        mul_a = 32'(ndc_off(ny_q));
        mul_b = {19'd0, 13'(eff_h)};
      end
      ST_AREA, ST_EDGE: begin
        mul_a = half_q ? 32'(dy_a) : 32'(dx_a);
        mul_b = half_q ? 32'(dx_p) : 32'(dy_p);
      end
      default: ;
    endcase
    map_num = mul_p;
    // truncate toward zero: numerator is never negative past -16384*size
    if (map_num < 0) map_res = CW'((map_num + 64'sd32767) >>> 15);
    else             map_res = CW'(map_num >>> 15);
    edet = DET_W'(prod_q - DET_W'(mul_p));
    area_s = edet;
  end

  // Barycentric clamps and colors.
  logic [NUM_W-1:0] bq0, bq1;
  always_comb begin
    bq0 = (b0_q > ONE) ? ONE : b0_q;
    bq1 = (dquo > ONE - bq0) ? ONE - bq0 : dquo;
    if (area_q == '0) begin
      bq0 = '0;
      bq1 = '0;
    end
    b1c = bq1;
    b2c = ONE - bq0 - bq1;
    thr = NUM_W'((NUM_W'(ew_q) << FRAC_BITS) >> 16);
    gray = (32'(z0_q) * 32'sd255);
    gray = (gray < 0) ? -((-gray) >>> 15) : (gray >>> 15);
  end

  function automatic logic [7:0] scale255(logic [NUM_W-1:0] b);
    logic [NUM_W+7:0] t;
    t = {b, 8'd0} - {8'd0, b};
    return 8'(t >> FRAC_BITS);
  endfunction

  logic in_acc, out_acc, covered;
  logic is_last, empty_box;
  assign in_acc    = in_valid_i && !in_stall_o;
  assign out_acc   = out_valid_o && !out_stall_i;
  assign in_stall_o = (st_q != ST_IDLE);
  assign empty_box = (bx0_q >= bx1_q) || (by0_q >= by1_q);
  assign is_last   = (sx_q == bx1_q - 13'd1) && (sy_q == by1_q - 13'd1);
  assign covered   = !e0_q[DET_W-1] && !e1_q[DET_W-1] && !e2_q[DET_W-1];

  // Fragment color of the scanned pixel.
  logic       owr_d;
  logic [7:0] or_d, og_d, ob_d, gray8;
  always_comb begin
    gray8 = (gray < 0) ? 8'd0 : (gray > 255) ? 8'd255 : 8'(gray);
    owr_d = 1'b0;
    or_d  = '0;
    og_d  = '0;
    ob_d  = '0;
    if (!empty_box && covered) begin
      owr_d = 1'b1;
      case (mode_q)
        MODE_BARY: begin
          or_d = scale255(bq0);
          og_d = scale255(b1c);
          ob_d = scale255(b2c);
        end
        MODE_WIRE: begin
          if (!(bq0 > thr && b1c > thr && b2c > thr)) og_d = 8'd255;
          else owr_d = 1'b0;
        end
        default: begin
          or_d = gray8;
          og_d = gray8;
          ob_d = gray8;
        end
      endcase
    end
  end

  always_comb begin
    dctl.start = 1'b0;
    dnum = '0;
    if (st_q == ST_EDGE && half_q && eidx_q == 2'd2 && area_q != '0
        && (mode_q == MODE_BARY || mode_q == MODE_WIRE) && !edet[DET_W-1]
        && !e0_q[DET_W-1] && !e1_q[DET_W-1]) begin
      dctl.start = 1'b1;
      dnum = NUM_W'(e1_q) << FRAC_BITS;
    end else if (st_q == ST_DIV0 && dsts.done) begin
      dctl.start = 1'b1;
      dnum = NUM_W'(e2_q) << FRAC_BITS;
    end
  end

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: if (in_acc) begin
        if (command_i == CMD_LOAD) st_d = (vertex_select_i == 2'd3) ? ST_IDLE : ST_MAPX;
        else                       st_d = ST_SETUP;
      end
      ST_MAPX:  st_d = ST_MAPY;
      ST_MAPY:  st_d = ST_IDLE;
      ST_SETUP: st_d = setup_q ? ST_EDGE : ST_AREA;
      ST_AREA:  if (half_q) st_d = empty_box ? ST_COLOR : ST_EDGE;
      ST_EDGE:  if (half_q && eidx_q == 2'd2) st_d = dctl.start ? ST_DIV0 : ST_COLOR;
      ST_DIV0:  if (dsts.done) st_d = ST_DIV1;
      ST_DIV1:  if (dsts.done) st_d = ST_COLOR;
      ST_COLOR: st_d = ST_OUT;
      ST_OUT:   if (out_acc) st_d = ST_IDLE;
      default:  st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      setup_q <= 1'b0;
      half_q  <= 1'b0;
      eidx_q  <= '0;
      for (int i = 0; i < 3; i++) begin
        vx_q[i] <= '0;
        vy_q[i] <= '0;
      end
      z0_q   <= '0;
      bx0_q  <= '0; bx1_q <= '0; by0_q <= '0; by1_q <= '0;
      sx_q   <= '0; sy_q  <= '0;
      area_q <= '0;
      e0_q   <= '0; e1_q  <= '0; e2_q  <= '0;
    end else begin
      st_q <= st_d;
      case (st_q)
        ST_IDLE: if (in_acc && command_i == CMD_LOAD && vertex_select_i != 2'd3) begin
          setup_q <= 1'b0;
          if (vertex_select_i == 2'd0) z0_q <= ndc_z_i;
        end
        ST_MAPX: vx_q[sel_q] <= map_res;
        ST_MAPY: vy_q[sel_q] <= map_res;
        ST_SETUP: begin
          half_q <= 1'b0;
          eidx_q <= '0;
          if (!setup_q) begin
            bx0_q <= nbx0; bx1_q <= nbx1; by0_q <= nby0; by1_q <= nby1;
            sx_q  <= nbx0; sy_q  <= nby0;
          end
        end
        ST_AREA: begin
          half_q <= !half_q;
          if (half_q) begin
            setup_q <= 1'b1;
            if (area_s < 0) begin
              vx_q[1] <= vx_q[2]; vx_q[2] <= vx_q[1];
              vy_q[1] <= vy_q[2]; vy_q[2] <= vy_q[1];
              area_q  <= DET_W'(-area_s);
            end else begin
              area_q  <= DET_W'(area_s);
            end
          end
        end
        ST_EDGE: begin
          half_q <= !half_q;
          if (half_q) begin
            eidx_q <= eidx_q + 2'd1;
            case (eidx_q)
              2'd0:    e0_q <= edet;
              2'd1:    e1_q <= edet;
              default: e2_q <= edet;
            endcase
          end
        end
        ST_COLOR: begin
          if (empty_box) begin
            setup_q <= 1'b0;
          end else if (is_last) begin
            setup_q <= 1'b0;
          end else if (sx_q + 13'd1 >= bx1_q) begin
            sx_q <= bx0_q;
            sy_q <= sy_q + 13'd1;
          end else begin
            sx_q <= sx_q + 13'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sel_q <= vertex_select_i;
      nx_q  <= ndc_x_i;
      ny_q  <= ndc_y_i;
    end
    if (st_q == ST_AREA || st_q == ST_EDGE) prod_q <= DET_W'(mul_p);
    if (st_q == ST_DIV0 && dsts.done) b0_q <= dquo;
    if (st_q == ST_EDGE || st_q == ST_AREA) if (!half_q) b0_q <= '0;
    if (st_q == ST_COLOR) begin
      opx_q   <= empty_box ? 12'd0 : sx_q[11:0];
      opy_q   <= empty_box ? 12'd0 : sy_q[11:0];
      olast_q <= empty_box || is_last;
      owr_q   <= owr_d;
      or_q    <= or_d;
      og_q    <= og_d;
      ob_q    <= ob_d;
    end
  end

  assign out_valid_o   = (st_q == ST_OUT);
  assign pixel_x_o     = opx_q;
  assign pixel_y_o     = opy_q;
  assign write_pixel_o = owr_q;
  assign red_o         = or_q;
  assign green_o       = og_q;
  assign blue_o        = ob_q;
  assign last_o        = olast_q;

endmodule

// File: verif/edge_function_triangle_raster_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// edge_function_triangle_raster_tb
// Self-checking bench for the triangle rasterizer. Vertex loads and scan steps
// go in as beats with random bursts and gaps, while the output side stalls on
// its own pattern. Each accepted step is predicted by a local rasterizer model
// and the pixel beats are compared field by field. Frame size, draw mode and
// edge width change between phases over several settings, extremes included.
// ----------------------------------------------------------------------------
module edge_function_triangle_raster_tb;
  import eftr_pkg::*;

  typedef struct {
    logic               cmd;
    logic [1:0]         sel;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
  } raster_cmd_t;

  typedef struct packed {
    logic [11:0] px;
    logic [11:0] py;
    logic        wr;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic        last;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic command_i = CMD_LOAD;
  logic [1:0] vertex_select_i = '0;
  logic signed [15:0] ndc_x_i = '0, ndc_y_i = '0, ndc_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [11:0] pixel_x_o, pixel_y_o;
  logic write_pixel_o, last_o;
  logic [7:0] red_o, green_o, blue_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  edge_function_triangle_raster uut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("edge_function_triangle_raster_tb NOT OK");
    $finish;
  end

  // ---- local model state ----
  int unsigned cfg_width = 640, cfg_height = 480, cfg_mode = 0, cfg_edge = 3277;
  longint vtx_x[3], vtx_y[3], depth0, box[4], cur_x, cur_y, area2;
  bit     box_live;

  raster_cmd_t pending_cmds[$];
  pixel_t      expected_pixels[$];
  int          errors = 0;

  function automatic longint clamp_size(int unsigned reg_val);
    return (reg_val > 4096) ? 4096 : longint'(reg_val);
  endfunction

  function automatic longint to_pixel(logic signed [15:0] c, int unsigned reg_val);
    return ((longint'(c) + 16384) * clamp_size(reg_val)) / 32768;
  endfunction

  function automatic longint edge_fn(longint ax, longint ay, longint bx, longint by);
    return ax * by - ay * bx;
  endfunction

  function automatic void clip_span(longint lo, longint hi, longint size,
                                    output longint olo, output longint ohi);
    olo = (lo < 0) ? 0 : lo;
    ohi = (hi > size) ? size : hi;
    if (olo > size) olo = size;
    if (ohi < olo) ohi = olo;
  endfunction

  function automatic void setup_triangle();
    longint mnx, mxx, mny, mxy, t;
    mnx = vtx_x[0]; mxx = vtx_x[0]; mny = vtx_y[0]; mxy = vtx_y[0];
    for (int i = 1; i < 3; i++) begin
      if (vtx_x[i] < mnx) mnx = vtx_x[i];
      if (vtx_x[i] > mxx) mxx = vtx_x[i];
      if (vtx_y[i] < mny) mny = vtx_y[i];
      if (vtx_y[i] > mxy) mxy = vtx_y[i];
    end
    clip_span(mnx, mxx, clamp_size(cfg_width), box[0], box[1]);
    clip_span(mny, mxy, clamp_size(cfg_height), box[2], box[3]);
    area2 = edge_fn(vtx_x[1] - vtx_x[0], vtx_y[1] - vtx_y[0],
                    vtx_x[2] - vtx_x[0], vtx_y[2] - vtx_y[0]);
    if (area2 < 0) begin
      // clockwise: swap vertices 1 and 2
      t = vtx_x[1]; vtx_x[1] = vtx_x[2]; vtx_x[2] = t;
      t = vtx_y[1]; vtx_y[1] = vtx_y[2]; vtx_y[2] = t;
      area2 = -area2;
    end
    area2 = area2 & 64'hFFFF_FFFF;
    cur_x = box[0];
    cur_y = box[2];
    box_live = 1'b1;
  endfunction

  function automatic bit rasterize(raster_cmd_t c, output pixel_t p);
    longint e0, e1, e2, b0, b1, b2, gray, one;
    bit lst;
    p = '{default: '0};
    if (c.cmd == CMD_LOAD) begin
      if (c.sel == 2'd3) return 1'b0;
      vtx_x[c.sel] = to_pixel(c.nx, cfg_width);
      vtx_y[c.sel] = to_pixel(c.ny, cfg_height);
      if (c.sel == 2'd0) depth0 = longint'(c.nz);
      box_live = 1'b0;
      return 1'b0;
    end
    if (!box_live) setup_triangle();
    if (box[0] >= box[1] || box[2] >= box[3]) begin
      p.last = 1'b1;
      box_live = 1'b0;
      return 1'b1;
    end
    e0 = edge_fn(vtx_x[1] - vtx_x[0], vtx_y[1] - vtx_y[0], cur_x - vtx_x[0], cur_y - vtx_y[0]);
    e1 = edge_fn(vtx_x[2] - vtx_x[1], vtx_y[2] - vtx_y[1], cur_x - vtx_x[1], cur_y - vtx_y[1]);
    e2 = edge_fn(vtx_x[0] - vtx_x[2], vtx_y[0] - vtx_y[2], cur_x - vtx_x[2], cur_y - vtx_y[2]);
    lst = (cur_x == box[1] - 1) && (cur_y == box[3] - 1);
    p.px = cur_x[11:0];
    p.py = cur_y[11:0];
    p.last = lst;
    if (e0 >= 0 && e1 >= 0 && e2 >= 0) begin
      one = 64'd1 << 16;
      b0 = 0;
      b1 = 0;
      if (area2 != 0) begin
        b0 = (e1 << 16) / area2;
        b1 = (e2 << 16) / area2;
        if (b0 > one) b0 = one;
        if (b1 > one - b0) b1 = one - b0;
      end
      b2 = one - b0 - b1;
      p.wr = 1'b1;
      if (cfg_mode == MODE_BARY) begin
        p.r = 8'((255 * b0) >> 16);
        p.g = 8'((255 * b1) >> 16);
        p.b = 8'((255 * b2) >> 16);
      end else if (cfg_mode == MODE_WIRE) begin
        if (b0 > cfg_edge && b1 > cfg_edge && b2 > cfg_edge) p.wr = 1'b0;
        else p.g = 8'd255;
      end else begin
        gray = (255 * depth0) / 32768;
        if (gray < 0) gray = 0;
        if (gray > 255) gray = 255;
        p.r = 8'(gray); p.g = 8'(gray); p.b = 8'(gray);
      end
    end
    if (lst) begin
      box_live = 1'b0;
    end else if (cur_x + 1 >= box[1]) begin
      cur_x = box[0];
      cur_y = cur_y + 1;
    end else begin
      cur_x = cur_x + 1;
    end
    return 1'b1;
  endfunction

  // ---- input driver ----
  bit in_beat = 1'b0;
  int burst_left = 0, gap_left = 0;

  always @(negedge clk_i) begin
    raster_cmd_t c;
    if (rst_ni && (!in_valid_i || in_beat)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        c = pending_cmds.pop_front();
        command_i <= c.cmd;
        vertex_select_i <= c.sel;
        ndc_x_i <= c.nx;
        ndc_y_i <= c.ny;
        ndc_z_i <= c.nz;
        in_valid_i <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 14);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---- output stall pattern ----
  int stall_mode = 0, stall_left = 0;

  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(20, 300);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= $urandom_range(0, 1);
      default: out_stall_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // ---- monitor and checker ----
  always @(posedge clk_i) begin
    pixel_t exp_p, got_p;
    raster_cmd_t c;
    in_beat <= in_valid_i && !in_stall_o;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_p = '{pixel_x_o, pixel_y_o, write_pixel_o, red_o, green_o, blue_o, last_o};
      if (expected_pixels.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected pixel beat x=%0d y=%0d", pixel_x_o, pixel_y_o);
      end else begin
        exp_p = expected_pixels.pop_front();
        if (got_p !== exp_p) begin
          errors++;
          if (errors <= 10)
            $display("pixel mismatch: exp x=%0d y=%0d w=%b rgb=%0d,%0d,%0d last=%b / got x=%0d y=%0d w=%b rgb=%0d,%0d,%0d last=%b",
                     exp_p.px, exp_p.py, exp_p.wr, exp_p.r, exp_p.g, exp_p.b, exp_p.last,
                     got_p.px, got_p.py, got_p.wr, got_p.r, got_p.g, got_p.b, got_p.last);
        end
      end
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      c = '{command_i, vertex_select_i, ndc_x_i, ndc_y_i, ndc_z_i};
      if (rasterize(c, exp_p)) expected_pixels.push_back(exp_p);
    end
  end

  // ---- register access ----
  task automatic reg_write(logic [CFG_ADDR_W-1:0] addr, logic [31:0] data, int wbits);
    logic [31:0] mask;
    mask = (32'd1 << wbits) - 1;
    @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b1; paddr = addr; pwdata = data; penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    pwrite = 1'b0; penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    if ((prdata & mask) !== (data & mask)) begin
      errors++;
      if (errors <= 10) $display("readback addr %0h: exp %0h got %0h", addr, data & mask, prdata & mask);
    end
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0;
    case (addr)
      REG_FRAME_WIDTH:  cfg_width  = data & 32'h1FFF;
      REG_FRAME_HEIGHT: cfg_height = data & 32'h1FFF;
      REG_DRAW_MODE:    cfg_mode   = data & 32'h3;
      default:          cfg_edge   = data & 32'hFFFF;
    endcase
  endtask

  task automatic push_cmd(logic c, logic [1:0] s, logic signed [15:0] x,
                          logic signed [15:0] y, logic signed [15:0] z);
    pending_cmds.push_back('{c, s, x, y, z});
  endtask

  function automatic logic signed [15:0] rand_ndc();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 34000)) - 16'sd17000;
  endfunction

  task automatic wait_drained();
    wait (pending_cmds.size() == 0 && !in_valid_i && expected_pixels.size() == 0);
    // loads give no beat; let the last one finish
    repeat (300) @(posedge clk_i);
  endtask

  int unsigned ph_w[8]  = '{16, 8, 32, 1, 4096, 8191, 0, 12};
  int unsigned ph_h[8]  = '{12, 8, 20, 1, 4096, 0, 7, 10};
  int unsigned ph_m[8]  = '{MODE_GRAY, MODE_BARY, MODE_WIRE, MODE_WIRE, MODE_BARY, MODE_RSVD,
                            MODE_GRAY, MODE_WIRE};
  int unsigned ph_e[8]  = '{3277, 0, 65535, 20000, 3277, 100, 65535, 12000};

  initial begin
    int count, steps;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    for (int ph = 0; ph < 8; ph++) begin
      reg_write(REG_FRAME_WIDTH, ph_w[ph], 13);
      reg_write(REG_FRAME_HEIGHT, ph_h[ph], 13);
      reg_write(REG_DRAW_MODE, (ph == 7) ? $urandom_range(0, 3) : ph_m[ph], 2);
      reg_write(REG_EDGE_WIDTH, (ph == 3) ? $urandom_range(0, 65535) : ph_e[ph], 16);
      if (ph == 0) begin
        // extremes, ignored select, zero area, clockwise and off-screen boxes
        push_cmd(CMD_STEP, 2'd0, 0, 0, 0);
        push_cmd(CMD_LOAD, 2'd0, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
        push_cmd(CMD_LOAD, 2'd1, 16'sh7FFF, 16'sh8000, 16'sh8000);
        push_cmd(CMD_LOAD, 2'd2, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        push_cmd(CMD_LOAD, 2'd3, 16'sh1234, 16'sh4321, 16'sh7777);
        repeat (4) push_cmd(CMD_STEP, 2'd3, 16'shFFFF, 16'shFFFF, 16'shFFFF);
        push_cmd(CMD_LOAD, 2'd0, 16'sh8000, 16'sh8000, 16'sh8000);
        push_cmd(CMD_LOAD, 2'd1, 16'sh8000, 16'sh8000, 0);
        push_cmd(CMD_LOAD, 2'd2, 16'sh8000, 16'sh8000, 0);
        push_cmd(CMD_STEP, 2'd0, 0, 0, 0);
        push_cmd(CMD_LOAD, 2'd0, 0, 0, 16'sh2000);
        push_cmd(CMD_LOAD, 2'd1, 0, 0, 0);
        push_cmd(CMD_LOAD, 2'd2, 0, 0, 0);
        repeat (2) push_cmd(CMD_STEP, 2'd0, 0, 0, 0);
        push_cmd(CMD_LOAD, 2'd0, -16'sd16384, -16'sd16384, 16'sh4000);
        push_cmd(CMD_LOAD, 2'd1, -16'sd16384, 16'sd16383, 0);
        push_cmd(CMD_LOAD, 2'd2, 16'sd16383, -16'sd16384, 0);
        repeat (5) push_cmd(CMD_STEP, 2'd0, 0, 0, 0);
      end
      count = 0;
      while (count < 205) begin
        if ($urandom_range(0, 4) != 0) begin
          for (int v = 0; v < 3; v++)
            push_cmd(CMD_LOAD, 2'(v), rand_ndc(), rand_ndc(), 16'($urandom));
          steps = (ph == 4) ? $urandom_range(1, 20) : $urandom_range(1, 90);
          for (int s = 0; s < steps; s++)
            push_cmd(CMD_STEP, 2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
          count += 3 + steps;
        end else begin
          push_cmd(1'($urandom), 2'($urandom), rand_ndc(), rand_ndc(), 16'($urandom));
          count++;
        end
      end
      wait_drained();
    end
    if (errors == 0) begin
      $display("edge_function_triangle_raster_tb OK");
    end else begin
      $display("edge_function_triangle_raster_tb NOT OK");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/eftr_pkg.sv
rtl/eftr_div.sv
rtl/edge_function_triangle_raster.sv
verif/edge_function_triangle_raster_tb.sv
